[rtl/core/lwpc_pkg.sv]
// ----------------------------------------------------------------------------
// lwpc_pkg
// Shared constants and types of the line walk path counter.
// ----------------------------------------------------------------------------
package lwpc_pkg;

  localparam int MAX_POSITIONS = 32;
  localparam int MAX_STEPS     = 62;
  localparam int FIELD_W       = 6;
  localparam int COUNT_W       = 63;
  localparam int POS_IDX_W     = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_ARG = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lwpc_state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } lwpc_cell_ctl_t;

endpackage

[rtl/core/lwpc_cell.sv]
// ----------------------------------------------------------------------------
// lwpc_cell
// One position of the walk row: holds the walk count of its position and
// replaces it with the sum of its neighbors' counts on every move (zero if beyond the line).
// ----------------------------------------------------------------------------
module lwpc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lwpc_pkg::lwpc_cell_ctl_t      ctl,
  input  logic                          seed,
  input  logic                          active,
  input  logic [lwpc_pkg::COUNT_W-1:0]  left_count,
  input  logic [lwpc_pkg::COUNT_W-1:0]  right_count,
  output logic [lwpc_pkg::COUNT_W-1:0]  count
);
  import lwpc_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               active_r;

  always_comb begin
    count_nxt = count_r;
    if (ctl.load) begin
      count_nxt = {{(COUNT_W-1){1'b0}}, seed};
    end else if (ctl.advance) begin
      count_nxt = active_r ? (left_count + right_count) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      active_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctl.load) begin
        active_r <= active;
      end
    end
  end

  assign count = count_r;

endmodule

[rtl/core/lwpc_ctrl.sv]
// ----------------------------------------------------------------------------
// lwpc_ctrl
// Request check, move counter, sequencer of the cell row and result register.
// ----------------------------------------------------------------------------
module lwpc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_positions,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_start_position,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_target_position,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_steps,
  input  logic [lwpc_pkg::COUNT_W-1:0]    sel_count,
  output logic [lwpc_pkg::POS_IDX_W-1:0]  target_idx,
  output lwpc_pkg::lwpc_cell_ctl_t        cell_ctl,
  output logic                            out_valid,
  output logic [lwpc_pkg::COUNT_W-1:0]    out_walk_count,
  output logic                            out_status
);
  import lwpc_pkg::*;

  lwpc_state_t          state_r;
  lwpc_state_t          state_nxt;
  logic [FIELD_W-1:0]   steps_left_r;
  logic [FIELD_W-1:0]   steps_left_nxt;
  logic [POS_IDX_W-1:0] target_r;
  logic                 bad_req;
  logic                 accept;
  logic                 finish;
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   out_walk_count_r;
  logic                 out_status_r;

  assign bad_req = (in_positions < FIELD_W'(2)) ||
                   (int'(in_positions) > MAX_POSITIONS) ||
                   (in_start_position == '0) || (in_start_position > in_positions) ||
                   (in_target_position == '0) || (in_target_position > in_positions);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !bad_req) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (steps_left_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy             = (state_r == ST_RUN);
    accept           = (state_r == ST_IDLE) && start;
    cell_ctl.load    = accept && !bad_req;
    cell_ctl.advance = (state_r == ST_RUN) && (steps_left_r != '0);
    finish           = (state_r == ST_RUN) && (steps_left_r == '0);
  end

  always_comb begin
    steps_left_nxt = steps_left_r;
    if (cell_ctl.load) begin
      steps_left_nxt = (int'(in_steps) > MAX_STEPS) ? FIELD_W'(MAX_STEPS) : in_steps;
    end else if (cell_ctl.advance) begin
      steps_left_nxt = steps_left_r - FIELD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      steps_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      steps_left_r <= steps_left_nxt;
      out_valid_r  <= (accept && bad_req) || finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ctl.load) begin
      target_r <= POS_IDX_W'(in_target_position - FIELD_W'(1));
    end
    if ((accept && bad_req) || finish) begin
      out_walk_count_r <= finish ? sel_count : '0;
      out_status_r     <= finish ? STATUS_OK : STATUS_BAD_ARG;
    end
  end

  assign target_idx     = target_r;
  assign out_valid      = out_valid_r;
  assign out_walk_count = out_walk_count_r;
  assign out_status     = out_status_r;

endmodule

[rtl/core/line_walk_path_counter.sv]
// ----------------------------------------------------------------------------
// line_walk_path_counter
// Counts walks of an exact number of unit moves between two positions on a
// line, using a row of cells that each hold one position's walk count.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A valid request
// makes min(steps, 62) moves in the cell row, one move per cycle, and its
// result is registered onto out_valid after the last move; a rejected request
// (status 1) is answered in the cycle after it is taken, with busy staying
// low. Each result is shown for one cycle only: the receiver cannot stall.
// ----------------------------------------------------------------------------
module line_walk_path_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_positions,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_start_position,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_target_position,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_steps,
  output logic                            out_valid,
  output logic [lwpc_pkg::COUNT_W-1:0]    out_walk_count,
  output logic                            out_status
);
  import lwpc_pkg::*;

  lwpc_cell_ctl_t       cell_ctl;
  logic [POS_IDX_W-1:0] target_idx;
  logic [COUNT_W-1:0]   cell_count [MAX_POSITIONS];
  logic [COUNT_W-1:0]   sel_count;

  lwpc_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_positions       (in_positions),
    .in_start_position  (in_start_position),
    .in_target_position (in_target_position),
    .in_steps           (in_steps),
    .sel_count          (sel_count),
    .target_idx         (target_idx),
    .cell_ctl           (cell_ctl),
    .out_valid          (out_valid),
    .out_walk_count     (out_walk_count),
    .out_status         (out_status)
  );

  for (genvar p = 0; p < MAX_POSITIONS; p++) begin : g_cell
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;

    if (p == 0) begin : g_first
      assign left_count = '0;
    end else begin : g_left
      assign left_count = cell_count[p-1];
    end

    if (p == MAX_POSITIONS - 1) begin : g_last
      assign right_count = '0;
    end else begin : g_right
      assign right_count = cell_count[p+1];
    end

    lwpc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl),
      .seed        (int'(in_start_position) == p + 1),
      .active      (int'(in_positions) > p),
      .left_count  (left_count),
      .right_count (right_count),
      .count       (cell_count[p])
    );
  end

  assign sel_count = cell_count[target_idx];

  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_BAD_ARG) |-> out_walk_count == '0)
    else $error("rejected request carries a nonzero count");

  a_run_from_request : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a request");

  a_ok_after_run : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_OK) |-> $past(busy) && !busy)
    else $error("good result not at the end of a run");

  a_reject_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_BAD_ARG) |-> $past(start) && !$past(busy) && !busy)
    else $error("rejected result without an idle request");

endmodule

[bench/lwpc_checker.sv]
// ----------------------------------------------------------------------------
// lwpc_checker
// Watches the request and result ports of the line walk path counter,
// predicts each walk count from its own copy of the count row and compares
// every result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lwpc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_positions,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_start_position,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_target_position,
  input  logic [lwpc_pkg::FIELD_W-1:0]    in_steps,
  input  logic                            out_valid,
  input  logic [lwpc_pkg::COUNT_W-1:0]    out_walk_count,
  input  logic                            out_status,
  output int                              fail_count,
  output int                              pending_walks
);
  import lwpc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] walk_count;
    logic               status;
  } walk_result_t;

  logic [COUNT_W-1:0] walk_row [MAX_POSITIONS];
  logic [FIELD_W-1:0] moves_left;
  walk_result_t       expected_walks [$];

  initial begin
    fail_count    = 0;
    pending_walks = 0;
    moves_left    = '0;
    foreach (walk_row[i]) walk_row[i] = '0;
  end

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic predict_walk(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] s,
                              input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] m,
                              output walk_result_t res);
    logic [COUNT_W-1:0] next_row [MAX_POSITIONS];
    int p;
    if (n < 2 || n > MAX_POSITIONS || s < 1 || s > n || t < 1 || t > n) begin
      // bad argument leaves the row untouched
      res.walk_count = '0;
      res.status     = STATUS_BAD_ARG;
    end else begin
      for (p = 0; p < MAX_POSITIONS; p++) walk_row[p] = '0;
      walk_row[POS_IDX_W'(s - FIELD_W'(1))] = COUNT_W'(1);
      moves_left = (m > MAX_STEPS) ? FIELD_W'(MAX_STEPS) : m;
      while (moves_left > 0) begin
        for (p = 0; p < n; p++) begin
          next_row[p] = '0;
          if (p > 0) next_row[p] = next_row[p] + walk_row[p - 1];
          if (p + 1 < n) next_row[p] = next_row[p] + walk_row[p + 1];
        end
        for (p = 0; p < n; p++) walk_row[p] = next_row[p];
        moves_left = moves_left - FIELD_W'(1);
      end
      res.walk_count = walk_row[POS_IDX_W'(t - FIELD_W'(1))];
      res.status     = STATUS_OK;
    end
  endtask

  always @(posedge clk) begin
    walk_result_t want;
    walk_result_t got_pred;
    if (rst_n) begin
      // results first: a result seen at this edge belongs to an older request
      if (out_valid) begin
        if (expected_walks.size() == 0) begin
          report_mismatch("unexpected result, walk_count", out_walk_count, '0);
        end else begin
          want = expected_walks.pop_front();
          if (out_walk_count !== want.walk_count)
            report_mismatch("walk_count", out_walk_count, want.walk_count);
          if (out_status !== want.status)
            report_mismatch("status", COUNT_W'(out_status), COUNT_W'(want.status));
        end
      end
      if (start && !busy) begin
        predict_walk(in_positions, in_start_position, in_target_position, in_steps,
                     got_pred);
        expected_walks.push_back(got_pred);
      end
    end
    pending_walks <= expected_walks.size();
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random walk requests into the line walk path counter
// with random gaps or back to back, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import lwpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int DRAIN_CYCLES   = 80;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FIELD_W-1:0]  in_positions;
  logic [FIELD_W-1:0]  in_start_position;
  logic [FIELD_W-1:0]  in_target_position;
  logic [FIELD_W-1:0]  in_steps;
  logic                out_valid;
  logic [COUNT_W-1:0]  out_walk_count;
  logic                out_status;
  int                  fail_count;
  int                  pending_walks;
  int                  idle_cycles = 0;
  bit                  no_gap_run  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_walk_path_counter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_positions       (in_positions),
    .in_start_position  (in_start_position),
    .in_target_position (in_target_position),
    .in_steps           (in_steps),
    .out_valid          (out_valid),
    .out_walk_count     (out_walk_count),
    .out_status         (out_status)
  );

  lwpc_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_positions       (in_positions),
    .in_start_position  (in_start_position),
    .in_target_position (in_target_position),
    .in_steps           (in_steps),
    .out_valid          (out_valid),
    .out_walk_count     (out_walk_count),
    .out_status         (out_status),
    .fail_count         (fail_count),
    .pending_walks      (pending_walks)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_walk_request(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] s,
                                   input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] m);
    int gap;
    gap = no_gap_run ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start              = 1'b1;
    in_positions       = n;
    in_start_position  = s;
    in_target_position = t;
    in_steps           = m;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_walk();
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] s;
    logic [FIELD_W-1:0] t;
    logic [FIELD_W-1:0] m;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // noise: any field pattern, mostly bad arguments
      n = FIELD_W'($urandom_range(0, 63));
      s = FIELD_W'($urandom_range(0, 63));
      t = FIELD_W'($urandom_range(0, 63));
      m = FIELD_W'($urandom_range(0, 63));
    end else begin
      n = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(2, 6)) :
                                        FIELD_W'($urandom_range(2, MAX_POSITIONS));
      s = FIELD_W'($urandom_range(1, n));
      t = FIELD_W'($urandom_range(1, n));
      pick = $urandom_range(0, 9);
      if (pick < 7)      m = FIELD_W'($urandom_range(0, 16));
      else if (pick < 9) m = FIELD_W'($urandom_range(17, 40));
      else               m = FIELD_W'($urandom_range(41, 63));
    end
    send_walk_request(n, s, t, m);
  endtask

  initial begin
    rst_n              = 1'b0;
    start              = 1'b0;
    in_positions       = '0;
    in_start_position  = '0;
    in_target_position = '0;
    in_steps           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: bad arguments, back to back
    no_gap_run = 1'b1;
    send_walk_request(6'd0, 6'd1, 6'd1, 6'd3);
    send_walk_request(6'd1, 6'd1, 6'd1, 6'd0);
    send_walk_request(6'd33, 6'd1, 6'd1, 6'd2);
    send_walk_request(6'd63, 6'd63, 6'd63, 6'd63);
    send_walk_request(6'd5, 6'd0, 6'd3, 6'd2);
    send_walk_request(6'd5, 6'd3, 6'd0, 6'd2);
    send_walk_request(6'd5, 6'd6, 6'd3, 6'd2);
    send_walk_request(6'd5, 6'd3, 6'd6, 6'd2);
    // zero steps, equal and unequal endpoints
    send_walk_request(6'd4, 6'd2, 6'd2, 6'd0);
    send_walk_request(6'd4, 6'd2, 6'd3, 6'd0);
    // smallest line, ends, parity
    send_walk_request(6'd2, 6'd1, 6'd2, 6'd1);
    send_walk_request(6'd2, 6'd1, 6'd1, 6'd1);
    send_walk_request(6'd2, 6'd2, 6'd1, 6'd63);
    send_walk_request(6'd3, 6'd1, 6'd3, 6'd2);
    // widest line, longest walks, step saturation
    no_gap_run = 1'b0;
    send_walk_request(6'd32, 6'd16, 6'd16, 6'd62);
    send_walk_request(6'd32, 6'd1, 6'd32, 6'd62);
    send_walk_request(6'd32, 6'd32, 6'd32, 6'd63);
    send_walk_request(6'd32, 6'd17, 6'd15, 6'd62);
    send_walk_request(6'd31, 6'd31, 6'd1, 6'd61);
    send_walk_request(6'd32, 6'd5, 6'd6, 6'd1);
    // bad argument right after a long walk
    send_walk_request(6'd32, 6'd16, 6'd17, 6'd63);
    send_walk_request(6'd32, 6'd33, 6'd1, 6'd1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) no_gap_run = ($urandom_range(0, 2) == 0);
      send_random_walk();
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_walks != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
